// ----- rtl/lcs_pkg.sv -----
// Shared types and constants for the linear contrast stretch block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int GRAY_BITS      = 16;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int DATA_BITS      = 32;
  localparam int ADDR_BITS      = 3;

  localparam logic [GRAY_BITS-1:0] MAX_GRAY_RESET = 16'd255;

  localparam logic [ADDR_BITS-3:0] REG_MAX_GRAY = 1'b0;

  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_APPLY   = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic                 frame_start;
    logic [GRAY_BITS-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [GRAY_BITS-1:0] stretched;
    logic                 flat;
  } out_t;

endpackage

// ----- rtl/lcs_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on lcs_pkg for the quotient width.
`timescale 1ns / 1ps

module lcs_div #(
  parameter int PIX_BITS = lcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [PIX_BITS+lcs_pkg::GRAY_BITS-1:0] dividend,
  input  logic [PIX_BITS-1:0]                  divisor,
  output logic                                 done,
  output logic [lcs_pkg::GRAY_BITS-1:0]        quotient
);

  localparam int QB = lcs_pkg::GRAY_BITS;
  localparam int CB = $clog2(QB);

  logic [PIX_BITS-1:0] rem;
  logic [QB-1:0]       lo;
  logic [CB-1:0]       cnt;
  logic                busy;
  logic [PIX_BITS:0]   trial;
  logic                ge;
  logic [PIX_BITS:0]   diff_w;

  // remainder always below divisor, so the trial value fits one extra bit
  always_comb begin
    trial  = {rem, lo[QB-1]};
    ge     = trial >= {1'b0, divisor};
    diff_w = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CB'(QB - 1);
      rem  <= dividend[PIX_BITS+QB-1:QB];
      lo   <= dividend[QB-1:0];
      done <= 1'b0;
    end else if (busy) begin
      rem  <= ge ? diff_w[PIX_BITS-1:0] : trial[PIX_BITS-1:0];
      lo   <= {lo[QB-2:0], ge};
      cnt  <= cnt - 1'b1;
      busy <= (cnt != '0);
      done <= (cnt == '0);
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient = lo;

endmodule

// ----- rtl/linear_contrast_stretch_top.sv -----
// Top level of the min-max contrast stretch: register port, range tracking,
// sequencer and result register. Depends on lcs_pkg and lcs_div.
`timescale 1ns / 1ps

// Two-pass min-max stretch. Stream a frame with mode low to measure (first
// pixel with frame_start high), then again with mode high to get one result
// per pixel. A measure pixel does not stall the input. An apply pixel that
// needs the quotient passes transfer, multiply, 16 divider steps, result
// capture and result load, the radix-2 divider giving one quotient bit per
// cycle; flat, inverted, at-or-below-min and at-or-above-max pixels skip the
// multiply and divider. in_stall is high while an apply pixel is in progress.
// A result waiting in the output register does not block the next transfer.
module linear_contrast_stretch_top #(
  parameter int PIXEL_BITS = lcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lcs_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lcs_pkg::out_t                   out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcs_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [lcs_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lcs_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  localparam int GB = lcs_pkg::GRAY_BITS;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t                state;
  logic [GB-1:0]         max_gray;
  logic [PIXEL_BITS-1:0] min_seen, max_seen;
  logic [PIXEL_BITS-1:0] min_next, max_next;
  logic [PIXEL_BITS-1:0] base_min, base_max;
  logic [PIXEL_BITS-1:0] pix, diff, dvsr;
  logic [GB-1:0]         res;
  logic                  res_flat;
  logic                  in_xfer, cfg_wr, out_load;
  logic                  flat_c, zero_c, sat_c;
  logic [PIXEL_BITS+GB-1:0] prod;
  logic                  div_done;
  logic [GB-1:0]         quot;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign prdata = (paddr[lcs_pkg::ADDR_BITS-1:2] == lcs_pkg::REG_MAX_GRAY) ?
                  {{(lcs_pkg::DATA_BITS-GB){1'b0}}, max_gray} : '0;

  always_comb begin
    pix      = in_data.pixel[PIXEL_BITS-1:0];
    base_min = in_data.frame_start ? max_gray[PIXEL_BITS-1:0] : min_seen;
    base_max = in_data.frame_start ? '0 : max_seen;
    min_next = (pix < base_min) ? pix : base_min;
    max_next = (pix > base_max) ? pix : base_max;
    flat_c   = (max_seen == min_seen);
    zero_c   = (max_seen < min_seen) || (pix <= min_seen);
    sat_c    = (pix >= max_seen);
  end

  // pixel strictly inside the range here, so the quotient stays below max_gray
  assign prod = diff * max_gray;

  lcs_div #(
    .PIX_BITS(PIXEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MUL),
    .dividend (prod),
    .divisor  (dvsr),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      max_gray  <= lcs_pkg::MAX_GRAY_RESET;
      min_seen  <= '1;
      max_seen  <= '0;
    end else begin
      if (cfg_wr && paddr[lcs_pkg::ADDR_BITS-1:2] == lcs_pkg::REG_MAX_GRAY) begin
        max_gray <= pwdata[GB-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.mode == lcs_pkg::MODE_MEASURE) begin
              min_seen <= min_next;
              max_seen <= max_next;
            end else begin
              diff     <= pix - min_seen;
              dvsr     <= max_seen - min_seen;
              res_flat <= flat_c;
              if (flat_c || zero_c) begin
                res   <= '0;
                state <= S_OUT;
              end else if (sat_c) begin
                res   <= max_gray;
                state <= S_OUT;
              end else begin
                res   <= '0;
                state <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res   <= quot;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data.stretched <= res;
            out_data.flat      <= res_flat;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
